### design/dopt_pkg.sv
// ----------------------------------------------------------------------------
// dopt_pkg: shared constants for the display-order slot table
// Field widths, status and mode codes, and reset values used by the RTL.
// ----------------------------------------------------------------------------
package dopt_pkg;

  localparam int SLOT_COUNT_DEF = 64;

  localparam int ORDER_W  = 32;
  localparam int HANDLE_W = 32;
  localparam int INDEX_W  = 8;
  localparam int STATUS_W = 2;
  localparam int TAKEN_W  = 6;
  localparam int ENTRY_W  = ORDER_W + HANDLE_W;

  localparam logic [ORDER_W-1:0]  MARK_RESET   = 32'h7FFF_FFFF;
  localparam logic [ORDER_W-1:0]  SIGN_FLIP    = 32'h8000_0000;
  localparam logic [HANDLE_W-1:0] HANDLE_NONE  = '0;

  localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_REJECT = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NONE   = 2'd2;

  localparam logic MODE_ADD = 1'b0;
  localparam logic MODE_GET = 1'b1;

endpackage

### design/dopt_ram.sv
// ----------------------------------------------------------------------------
// dopt_ram: generic single-write, single-read RAM
// One write port and one read port; read data registered.
// ----------------------------------------------------------------------------
module dopt_ram #(
  parameter int WIDTH = dopt_pkg::ENTRY_W,
  parameter int DEPTH = dopt_pkg::SLOT_COUNT_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### design/display_order_min_poc_table_unit.sv
// ----------------------------------------------------------------------------
// display_order_min_poc_table_unit: display-order slot table
// Add stores an order count and handle in a free slot; get extracts the slot
// with the lowest order count (highest index on ties) and empties it.
// Add reads the addressed slot and writes it in S_ADD (an out-of-range slot
// index goes straight to S_DONE); get passes S_SCAN and S_CLEAR to S_DONE,
// scanning one slot per cycle through the single read port of the table RAM.
// One item is in work at a time; input is held off while a result waits.
// Reset: synchronous; per-slot valid flops clear at once so every slot reads
// as empty (order 0x7FFFFFFF, handle zero); there is no clearing pass.
// ----------------------------------------------------------------------------
module display_order_min_poc_table_unit #(
  parameter int SLOT_COUNT = dopt_pkg::SLOT_COUNT_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [dopt_pkg::ORDER_W-1:0]   cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           mode,
  input  logic [dopt_pkg::INDEX_W-1:0]   slot_index,
  input  logic signed [dopt_pkg::ORDER_W-1:0] order_count,
  input  logic [dopt_pkg::HANDLE_W-1:0]  buffer_handle,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [dopt_pkg::STATUS_W-1:0]  status,
  output logic [dopt_pkg::TAKEN_W-1:0]   taken_slot,
  output logic [dopt_pkg::HANDLE_W-1:0]  taken_handle
);

  localparam int IDX_W = $clog2(SLOT_COUNT);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_ADD   = 5'b00010,
    S_SCAN  = 5'b00100,
    S_CLEAR = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  state_t state;

  logic [dopt_pkg::ORDER_W-1:0]  mark;
  logic [SLOT_COUNT-1:0]         slot_valid;
  logic                          rd_vld;

  // latched add item
  logic [IDX_W-1:0]              add_idx;
  logic [dopt_pkg::ORDER_W-1:0]  add_ord;
  logic [dopt_pkg::HANDLE_W-1:0] add_hnd;

  // scan bookkeeping
  logic [IDX_W-1:0]              issue_idx;
  logic [IDX_W-1:0]              cmp_idx;
  logic                          found;
  logic [dopt_pkg::ORDER_W-1:0]  best_key;
  logic [IDX_W-1:0]              best_idx;
  logic [dopt_pkg::HANDLE_W-1:0] best_hnd;

  // pending result
  logic [dopt_pkg::STATUS_W-1:0] res_status;
  logic [dopt_pkg::TAKEN_W-1:0]  res_slot;
  logic [dopt_pkg::HANDLE_W-1:0] res_hnd;

  // RAM ports
  logic                          ram_we;
  logic [IDX_W-1:0]              ram_waddr;
  logic [dopt_pkg::ENTRY_W-1:0]  ram_wdata;
  logic [IDX_W-1:0]              ram_raddr;
  logic [dopt_pkg::ENTRY_W-1:0]  ram_rdata;

  logic [dopt_pkg::ORDER_W-1:0]  cur_ord;
  logic [dopt_pkg::HANDLE_W-1:0] cur_hnd;
  logic [dopt_pkg::ORDER_W-1:0]  cur_key;
  logic                          cur_take;
  logic                          in_xfer;
  logic                          add_range_bad;

  dopt_ram #(
    .WIDTH (dopt_pkg::ENTRY_W),
    .DEPTH (SLOT_COUNT)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_ready      = (state == S_IDLE);
  assign in_xfer       = in_valid && in_ready;
  assign add_range_bad = (32'(slot_index) >= 32'(SLOT_COUNT));

  // a slot never written since reset reads as the reset contents
  assign cur_ord  = rd_vld ? ram_rdata[dopt_pkg::ENTRY_W-1:dopt_pkg::HANDLE_W]
                           : dopt_pkg::MARK_RESET;
  assign cur_hnd  = rd_vld ? ram_rdata[dopt_pkg::HANDLE_W-1:0] : dopt_pkg::HANDLE_NONE;
  assign cur_key  = cur_ord ^ dopt_pkg::SIGN_FLIP;
  assign cur_take = (cur_ord != mark) && (!found || cur_key <= best_key);

  always_comb begin
    ram_raddr = '0;
    case (state)
      S_IDLE: begin
        if (mode == dopt_pkg::MODE_ADD) begin
          ram_raddr = slot_index[IDX_W-1:0];
        end
      end
      S_SCAN:  ram_raddr = issue_idx;
      default: ram_raddr = '0;
    endcase
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = add_idx;
    ram_wdata = {add_ord, add_hnd};
    case (state)
      S_ADD: begin
        ram_we = (cur_hnd == dopt_pkg::HANDLE_NONE);
      end
      S_CLEAR: begin
        ram_we    = found;
        ram_waddr = best_idx;
        ram_wdata = {mark, dopt_pkg::HANDLE_NONE};
      end
      default: ram_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    rd_vld <= slot_valid[ram_raddr];
    if (rst) begin
      mark       <= dopt_pkg::MARK_RESET;
      slot_valid <= '0;
    end else begin
      if (cfg_we) begin
        mark <= cfg_data;
      end
      if (ram_we) begin
        slot_valid[ram_waddr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      found     <= 1'b0;
    end else begin
      // drop the result once transferred, unless a new one replaces it
      if (out_valid && out_ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_xfer) begin
            add_idx    <= slot_index[IDX_W-1:0];
            add_ord    <= order_count;
            add_hnd    <= buffer_handle;
            res_slot   <= '0;
            res_hnd    <= dopt_pkg::HANDLE_NONE;
            found      <= 1'b0;
            issue_idx  <= IDX_W'(1);
            cmp_idx    <= '0;
            if (mode == dopt_pkg::MODE_GET) begin
              state <= S_SCAN;
            end else if (add_range_bad) begin
              res_status <= dopt_pkg::ST_REJECT;
              state      <= S_DONE;
            end else begin
              state <= S_ADD;
            end
          end
        end
        S_ADD: begin
          res_status <= ram_we ? dopt_pkg::ST_OK : dopt_pkg::ST_REJECT;
          state      <= S_DONE;
        end
        S_SCAN: begin
          if (cur_take) begin
            found    <= 1'b1;
            best_key <= cur_key;
            best_idx <= cmp_idx;
            best_hnd <= cur_hnd;
          end
          issue_idx <= issue_idx + 1'b1;
          cmp_idx   <= cmp_idx + 1'b1;
          if (cmp_idx == IDX_W'(SLOT_COUNT - 1)) begin
            state <= S_CLEAR;
          end
        end
        S_CLEAR: begin
          if (found) begin
            res_status <= dopt_pkg::ST_OK;
            res_slot   <= dopt_pkg::TAKEN_W'(best_idx);
            res_hnd    <= best_hnd;
          end else begin
            res_status <= dopt_pkg::ST_NONE;
          end
          state <= S_DONE;
        end
        S_DONE: begin
          // hold until the output register is free
          if (!out_valid || out_ready) begin
            out_valid    <= 1'b1;
            status       <= res_status;
            taken_slot   <= res_slot;
            taken_handle <= res_hnd;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_no_write_in_scan: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> !ram_we)
    else $error("table written during a scan");

  a_scan_lockstep: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (issue_idx == cmp_idx + 1'b1))
    else $error("scan read and compare indices out of step");

  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR && found) |-> (ram_we && ram_waddr == best_idx &&
      ram_wdata[dopt_pkg::HANDLE_W-1:0] == dopt_pkg::HANDLE_NONE))
    else $error("taken slot not emptied");

  a_fail_zero_payload: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != dopt_pkg::ST_OK) |-> (taken_slot == '0 &&
      taken_handle == dopt_pkg::HANDLE_NONE))
    else $error("failed item carries a slot or handle");

  a_done_reaches_out: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && (!out_valid || out_ready)) |=> (out_valid && state == S_IDLE))
    else $error("result not moved to output register");
`endif

endmodule

### tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the display-order slot table
// Drives add and get items through the valid/ready input channel, predicts
// each result from a local copy of the table and the empty mark, and checks
// every output transfer field by field. Directed cases come first, then
// random phases under several empty-mark values and idle patterns.
// ----------------------------------------------------------------------------
module tb;

  localparam int SLOTS = dopt_pkg::SLOT_COUNT_DEF;

  typedef struct packed {
    logic [dopt_pkg::STATUS_W-1:0] status;
    logic [dopt_pkg::TAKEN_W-1:0]  slot;
    logic [dopt_pkg::HANDLE_W-1:0] handle;
  } take_result_t;

  logic                                clk;
  logic                                rst = 1'b1;
  logic                                cfg_we = 1'b0;
  logic [dopt_pkg::ORDER_W-1:0]        cfg_data = '0;
  logic                                in_valid = 1'b0;
  logic                                in_ready;
  logic                                mode = dopt_pkg::MODE_ADD;
  logic [dopt_pkg::INDEX_W-1:0]        slot_index = '0;
  logic signed [dopt_pkg::ORDER_W-1:0] order_count = '0;
  logic [dopt_pkg::HANDLE_W-1:0]       buffer_handle = '0;
  logic                                out_valid;
  logic                                out_ready = 1'b0;
  logic [dopt_pkg::STATUS_W-1:0]       status;
  logic [dopt_pkg::TAKEN_W-1:0]        taken_slot;
  logic [dopt_pkg::HANDLE_W-1:0]       taken_handle;

  // local copy of the table and the register
  logic signed [dopt_pkg::ORDER_W-1:0] tbl_order [SLOTS];
  logic [dopt_pkg::HANDLE_W-1:0]       tbl_handle [SLOTS];
  logic signed [dopt_pkg::ORDER_W-1:0] cur_mark;

  take_result_t pending_results [$];
  int err_count = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  display_order_min_poc_table_unit #(.SLOT_COUNT(SLOTS)) dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .mode         (mode),
    .slot_index   (slot_index),
    .order_count  (order_count),
    .buffer_handle(buffer_handle),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .status       (status),
    .taken_slot   (taken_slot),
    .taken_handle (taken_handle)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("Some tests failed");
    $finish;
  end

  function automatic void clear_table();
    cur_mark = dopt_pkg::MARK_RESET;
    for (int i = 0; i < SLOTS; i++) begin
      tbl_order[i]  = dopt_pkg::MARK_RESET;
      tbl_handle[i] = dopt_pkg::HANDLE_NONE;
    end
  endfunction

  function automatic bit table_has_buffer();
    for (int i = 0; i < SLOTS; i++)
      if (tbl_order[i] != cur_mark) return 1'b1;
    return 1'b0;
  endfunction

  // Apply one item to the local table and return the result it should give.
  function automatic take_result_t compute_take(input logic m,
                                                input logic [dopt_pkg::INDEX_W-1:0] idx,
                                                input logic signed [dopt_pkg::ORDER_W-1:0] ord,
                                                input logic [dopt_pkg::HANDLE_W-1:0] hnd);
    take_result_t r;
    bit found;
    int best;
    r = '{status: dopt_pkg::ST_OK, slot: '0, handle: '0};
    found = 1'b0;
    best = 0;
    if (m == dopt_pkg::MODE_ADD) begin
      if (idx >= SLOTS || tbl_handle[idx] != dopt_pkg::HANDLE_NONE) begin
        r.status = dopt_pkg::ST_REJECT;
      end else begin
        tbl_handle[idx] = hnd;
        tbl_order[idx]  = ord;
      end
    end else begin
      // ascending scan with <= keeps the highest index on a tie
      for (int i = 0; i < SLOTS; i++) begin
        if (tbl_order[i] != cur_mark && (!found || tbl_order[i] <= tbl_order[best])) begin
          found = 1'b1;
          best = i;
        end
      end
      if (!found) begin
        r.status = dopt_pkg::ST_NONE;
      end else begin
        r.slot   = best[dopt_pkg::TAKEN_W-1:0];
        r.handle = tbl_handle[best];
        tbl_handle[best] = dopt_pkg::HANDLE_NONE;
        tbl_order[best]  = cur_mark;
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    err_count++;
  endtask

  always @(posedge clk) begin
    out_ready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin : check_results
    take_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing pending", 32'(status), '0);
      end else begin
        want = pending_results.pop_front();
        if (status !== want.status)
          report_mismatch("status", 32'(status), 32'(want.status));
        if (taken_slot !== want.slot)
          report_mismatch("taken_slot", 32'(taken_slot), 32'(want.slot));
        if (taken_handle !== want.handle)
          report_mismatch("taken_handle", taken_handle, want.handle);
      end
    end
  end

  // Present one item and return at the edge of its transfer; valid stays up.
  task automatic send_item(input logic m, input logic [dopt_pkg::INDEX_W-1:0] idx,
                           input logic signed [dopt_pkg::ORDER_W-1:0] ord,
                           input logic [dopt_pkg::HANDLE_W-1:0] hnd);
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid      <= 1'b1;
    mode          <= m;
    slot_index    <= idx;
    order_count   <= ord;
    buffer_handle <= hnd;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(compute_take(m, idx, ord, hnd));
  endtask

  task automatic take_item();
    send_item(dopt_pkg::MODE_GET, dopt_pkg::INDEX_W'($urandom),
              dopt_pkg::ORDER_W'($urandom), dopt_pkg::HANDLE_W'($urandom));
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_mark(input logic signed [dopt_pkg::ORDER_W-1:0] value);
    wait_idle();
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we   <= 1'b0;
    cur_mark = value;
  endtask

  task automatic test_empty_get();
    take_item();
  endtask

  task automatic test_add_cases();
    send_item(dopt_pkg::MODE_ADD, 8'd0, 32'sh8000_0000, 32'hFFFF_FFFF);
    send_item(dopt_pkg::MODE_ADD, 8'd63, 32'sh7FFF_FFFE, 32'h0000_0001);
    send_item(dopt_pkg::MODE_ADD, 8'd64, 32'sd5, 32'h1111_1111);   // just past the table
    send_item(dopt_pkg::MODE_ADD, 8'd255, 32'sd5, 32'h2222_2222);
    send_item(dopt_pkg::MODE_ADD, 8'd0, 32'sd1, 32'h3333_3333);    // occupied
    send_item(dopt_pkg::MODE_ADD, 8'd5, 32'sd10, dopt_pkg::HANDLE_NONE); // overwritable
    send_item(dopt_pkg::MODE_ADD, 8'd5, -32'sd1, 32'hA5A5_A5A5);
    // never taken while the mark holds
    send_item(dopt_pkg::MODE_ADD, 8'd7, dopt_pkg::MARK_RESET, 32'h0000_1234);
    send_item(dopt_pkg::MODE_ADD, 8'd9, -32'sd1, 32'h5A5A_5A5A);
    send_item(dopt_pkg::MODE_ADD, 8'd62, 32'sd0, 32'h00FF_00FF);
  endtask

  task automatic test_get_order();
    // lowest order first, highest index on the tie, then empty
    repeat (6) take_item();
  endtask

  task automatic test_mark_change();
    write_mark(32'sd0);
    take_item();
    send_item(dopt_pkg::MODE_ADD, 8'd63, 32'sd0, 32'h0000_DEAD);
    take_item();
    write_mark(dopt_pkg::MARK_RESET);
    take_item();
    take_item();
  endtask

  task automatic random_item();
    logic m;
    logic [dopt_pkg::INDEX_W-1:0] idx;
    logic signed [dopt_pkg::ORDER_W-1:0] ord;
    logic [dopt_pkg::HANDLE_W-1:0] hnd;
    int pick;
    m   = ($urandom_range(99) < 35) ? dopt_pkg::MODE_GET : dopt_pkg::MODE_ADD;
    idx = ($urandom_range(9) == 0) ? dopt_pkg::INDEX_W'($urandom_range(255, SLOTS))
                                   : dopt_pkg::INDEX_W'($urandom_range(SLOTS - 1));
    pick = $urandom_range(99);
    if (pick < 40)      ord = $signed($urandom_range(8)) - 4;
    else if (pick < 50) ord = cur_mark;
    else if (pick < 60) begin
      case ($urandom_range(3))
        0:       ord = 32'sh8000_0000;
        1:       ord = 32'sh7FFF_FFFF;
        2:       ord = -32'sd1;
        default: ord = 32'sd0;
      endcase
    end else            ord = $urandom;
    hnd = ($urandom_range(9) == 0) ? dopt_pkg::HANDLE_NONE : dopt_pkg::HANDLE_W'($urandom);
    send_item(m, idx, ord, hnd);
  endtask

  task automatic test_random_phases();
    logic signed [dopt_pkg::ORDER_W-1:0] marks [8];
    int drained;
    marks = '{dopt_pkg::MARK_RESET, 32'sh8000_0000, 32'sd0, -32'sd1,
              $urandom, dopt_pkg::MARK_RESET, 32'sh7FFF_FFFE, $urandom};
    for (int p = 0; p < 8; p++) begin
      write_mark(marks[p]);
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 48; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 48; end
        default: begin send_idle_pct = 13; recv_stall_pct = 13; end
      endcase
      repeat (40) random_item();
      // empty the table so the final get finds nothing
      drained = 0;
      while (table_has_buffer() && drained < SLOTS + 6) begin
        take_item();
        drained++;
      end
      take_item();
    end
    send_idle_pct  = 0;
    recv_stall_pct = 0;
  endtask

  initial begin
    clear_table();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_empty_get();
    test_add_cases();
    test_get_order();
    test_mark_change();
    test_random_phases();
    wait_idle();
    repeat (SLOTS + 8) @(posedge clk);
    if (pending_results.size() != 0)
      report_mismatch("results never delivered", 32'(pending_results.size()), 0);
    if (err_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

### files.f
design/dopt_pkg.sv
design/dopt_ram.sv
design/display_order_min_poc_table_unit.sv
tb/tb.sv
